### rtl/core/rfa_pkg.sv
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and constants for the region frame allocator
// Request/response payloads, the decoded command and the operation codes.
// ----------------------------------------------------------------------------
package rfa_pkg;

   // Request kind codes as they arrive on the request channel
   localparam logic [1:0] KIND_LOAD           = 2'd0;
   localparam logic [1:0] KIND_ADDR_OF_FRAME  = 2'd1;
   localparam logic [1:0] KIND_FRAME_OF_ADDR  = 2'd2;
   localparam logic [1:0] KIND_ALLOC          = 2'd3;

   // Region type code that marks a region usable
   localparam logic [31:0] REGION_TYPE_USABLE = 32'd1;

   // Depth of the command queue between front and back
   localparam int CMD_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ADDR_OF_FRAME,
      OP_FRAME_OF_ADDR,
      OP_ALLOC
   } rfa_op_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        first_region;
      logic [63:0] region_base;
      logic [63:0] region_length;
      logic [31:0] region_type;
      logic [63:0] query_value;
   } rfa_req_type;

   typedef struct packed {
      logic        found;
      logic [63:0] result_value;
   } rfa_rsp_type;

   typedef struct packed {
      rfa_op_type  op;
      logic        first_region;
      logic        usable;
      logic [63:0] region_base;
      logic [63:0] region_length;
      logic [63:0] query_value;
   } rfa_cmd_type;

endpackage

### rtl/core/rfa_ram.sv
// ----------------------------------------------------------------------------
// rfa_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/rfa_cmd_fifo.sv
// ----------------------------------------------------------------------------
// rfa_cmd_fifo: short command queue between front and back
// Decouples request intake from the region-walk sequencer.
// ----------------------------------------------------------------------------
module rfa_cmd_fifo
   import rfa_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  rfa_cmd_type push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output rfa_cmd_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rfa_cmd_type   slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [CW-1:0] fill_ff;
   logic          push;
   logic          pop;

   assign push_ready = (fill_ff != CW'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + CW'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - CW'(1);
         end
      end
   end

endmodule

### rtl/core/rfa_front.sv
// ----------------------------------------------------------------------------
// rfa_front: request intake and decode
// Accepts request transactions, classifies them into commands, holds one
// command until the queue takes it.
// ----------------------------------------------------------------------------
module rfa_front
   import rfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  rfa_req_type req_data,
   output logic        push_valid,
   input  logic        push_ready,
   output rfa_cmd_type push_cmd
);

   logic        front_valid_ff;
   rfa_cmd_type front_cmd_ff;
   rfa_cmd_type cmd_in;
   logic        accept;

   always_comb begin
      cmd_in.first_region  = req_data.first_region;
      cmd_in.usable        = (req_data.region_type == REGION_TYPE_USABLE);
      cmd_in.region_base   = req_data.region_base;
      cmd_in.region_length = req_data.region_length;
      cmd_in.query_value   = req_data.query_value;
      case (req_data.kind)
         KIND_LOAD:          cmd_in.op = OP_LOAD;
         KIND_ADDR_OF_FRAME: cmd_in.op = OP_ADDR_OF_FRAME;
         KIND_FRAME_OF_ADDR: cmd_in.op = OP_FRAME_OF_ADDR;
         KIND_ALLOC:         cmd_in.op = OP_ALLOC;
         default:            cmd_in.op = OP_ALLOC;
      endcase
   end

   assign req_ready  = !front_valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = front_valid_ff;
   assign push_cmd   = front_cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (accept) begin
         front_valid_ff <= 1'b1;
      end else if (push_ready) begin
         front_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_cmd_ff <= cmd_in;
      end
   end

endmodule

### rtl/core/rfa_back.sv
// ----------------------------------------------------------------------------
// rfa_back: region table and walk sequencer
// Stores regions, walks the table for frame/address lookups and allocation,
// and holds the response register.
// ----------------------------------------------------------------------------
module rfa_back
   import rfa_pkg::*;
#(
   parameter int MAX_REGIONS = 8,
   parameter int PAGE_SHIFT  = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_pop,
   input  rfa_cmd_type cmd_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rfa_rsp_type rsp_data
);

   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam int FP_W  = 65 - PAGE_SHIFT;   // first page, can reach 2^(64-shift)
   localparam int CT_W  = 64 - PAGE_SHIFT;   // frame count
   localparam int ENT_W = FP_W + CT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_FETCH,
      S_TEST,
      S_HIT,
      S_DONE
   } state_type;

   typedef enum logic {
      PASS_ADDR,
      PASS_FRAME
   } pass_type;

   state_type    state_ff;
   pass_type     pass_ff;
   rfa_cmd_type  cmd_ff;
   logic [CNT_W-1:0] walk_ff;
   logic [CNT_W-1:0] count_ff;
   logic [63:0]  next_free_ff;
   logic [63:0]  cum_ff;
   logic [63:0]  key_ff;
   logic [63:0]  diff_ff;
   logic [FP_W-1:0] fp_ff;
   logic         hit_ff;
   logic [63:0]  val_ff;
   logic         rsp_valid_ff;
   rfa_rsp_type  rsp_ff;

   logic [ENT_W-1:0] rd_data;
   logic [FP_W-1:0]  ent_fp;
   logic [CT_W-1:0]  ent_ct;
   logic [63:0]      rhs;
   logic [64:0]      sub_wide;
   logic [63:0]      diff;
   logic             in_region;
   logic [63:0]      ent_ct_ext;
   logic [63:0]      hit_addr;
   logic [63:0]      hit_val;
   logic [FP_W-1:0]  ld_fp;
   logic [63:0]      len_m1;
   logic [CT_W-1:0]  ld_ct;
   logic [CNT_W-1:0] slot_base;
   logic             load_ok;
   logic             wr_en;
   logic             rd_en;
   logic             more_regions;
   logic             rsp_load;

   // Region table: first page and frame count per entry
   rfa_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_base[IDX_W-1:0]),
      .wr_data ({ld_fp, ld_ct}),
      .rd_en   (rd_en),
      .rd_addr (walk_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Load: precompute first page and frame count
   assign ld_fp     = {1'b0, cmd_ff.region_base[63:PAGE_SHIFT]} + FP_W'(1);
   assign len_m1    = cmd_ff.region_length - 64'd1;
   assign ld_ct     = (cmd_ff.usable && (cmd_ff.region_length != '0)) ?
                      len_m1[63:PAGE_SHIFT] : '0;
   assign slot_base = cmd_ff.first_region ? '0 : count_ff;
   assign load_ok   = (slot_base < CNT_W'(MAX_REGIONS));
   assign wr_en     = (state_ff == S_LOAD) && load_ok;

   // Walk: one region tested per fetch/test pair
   assign more_regions = (walk_ff < count_ff);
   assign rd_en        = (state_ff == S_FETCH) && more_regions;
   assign ent_fp       = rd_data[ENT_W-1:CT_W];
   assign ent_ct       = rd_data[CT_W-1:0];
   assign ent_ct_ext   = {{PAGE_SHIFT{1'b0}}, ent_ct};
   assign rhs          = (pass_ff == PASS_ADDR) ? cum_ff :
                         {{(64 - FP_W){1'b0}}, ent_fp};
   assign sub_wide     = {1'b0, key_ff} - {1'b0, rhs};
   assign diff         = sub_wide[63:0];
   assign in_region    = !sub_wide[64] && (diff < ent_ct_ext);

   assign hit_addr = ({{(64 - FP_W){1'b0}}, fp_ff} + diff_ff) << PAGE_SHIFT;
   assign hit_val  = (pass_ff == PASS_ADDR) ? hit_addr : (cum_ff + diff_ff);

   // Response register takes a new answer when the final pass is done
   assign rsp_load = (state_ff == S_DONE) &&
                     !((cmd_ff.op == OP_ALLOC) && (pass_ff == PASS_ADDR)) &&
                     (!rsp_valid_ff || rsp_ready);

   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff  <= cmd_data;
                  walk_ff <= '0;
                  cum_ff  <= '0;
                  case (cmd_data.op)
                     OP_LOAD: begin
                        state_ff <= S_LOAD;
                     end
                     OP_ADDR_OF_FRAME: begin
                        pass_ff  <= PASS_ADDR;
                        key_ff   <= cmd_data.query_value;
                        state_ff <= S_FETCH;
                     end
                     OP_FRAME_OF_ADDR: begin
                        pass_ff  <= PASS_FRAME;
                        key_ff   <= {{PAGE_SHIFT{1'b0}},
                                     cmd_data.query_value[63:PAGE_SHIFT]};
                        state_ff <= S_FETCH;
                     end
                     default: begin
                        pass_ff  <= PASS_ADDR;
                        key_ff   <= next_free_ff;
                        state_ff <= S_FETCH;
                     end
                  endcase
               end
            end
            S_LOAD: begin
               if (cmd_ff.first_region) begin
                  next_free_ff <= '0;
               end
               count_ff <= load_ok ? slot_base + CNT_W'(1) : slot_base;
               hit_ff   <= load_ok;
               val_ff   <= '0;
               state_ff <= S_DONE;
            end
            S_FETCH: begin
               if (more_regions) begin
                  state_ff <= S_TEST;
               end else begin
                  hit_ff   <= 1'b0;
                  val_ff   <= '0;
                  state_ff <= S_DONE;
               end
            end
            S_TEST: begin
               if (in_region) begin
                  diff_ff  <= diff;
                  fp_ff    <= ent_fp;
                  state_ff <= S_HIT;
               end else begin
                  cum_ff   <= cum_ff + ent_ct_ext;
                  walk_ff  <= walk_ff + CNT_W'(1);
                  state_ff <= S_FETCH;
               end
            end
            S_HIT: begin
               hit_ff   <= 1'b1;
               val_ff   <= hit_val;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if ((cmd_ff.op == OP_ALLOC) && (pass_ff == PASS_ADDR)) begin
                  // Second pass of allocate: frame of the address just found
                  pass_ff  <= PASS_FRAME;
                  key_ff   <= {{PAGE_SHIFT{1'b0}}, val_ff[63:PAGE_SHIFT]};
                  walk_ff  <= '0;
                  cum_ff   <= '0;
                  state_ff <= S_FETCH;
               end else if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.found        <= hit_ff;
                  rsp_ff.result_value <= val_ff;
                  if (cmd_ff.op == OP_ALLOC) begin
                     next_free_ff <= val_ff + 64'd1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

### rtl/core/region_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// region_frame_allocator_unit: page-frame allocator over a region table
// Loads memory regions, maps frames to addresses and back, allocates frames.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready/req_data) carries one transaction
//   per operation: load region, address of frame, frame of address, or
//   allocate. Response channel (rsp_valid/rsp_ready/rsp_data) returns exactly
//   one transaction per request, in request order.
//   The back-end walk sequencer takes one command at a time and tests one
//   table entry per fetch/test state pair (registered table read, then
//   compare); an allocate walks the table twice, a lookup once.
//   A two-entry command queue plus the front register keep accepting
//   requests while the back end works or the response waits.
//   Reset clears the region count, the next-free counter and all handshake
//   state; table contents are only read after being loaded.
//   When the receiver stalls, hold the response; the back end holds in its
//   done state and the queue fills, then req_ready drops.
// ----------------------------------------------------------------------------
module region_frame_allocator_unit
   import rfa_pkg::*;
#(
   parameter int MAX_REGIONS = 8,
   parameter int PAGE_SHIFT  = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  rfa_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rfa_rsp_type rsp_data
);

   // Front to queue
   logic        push_valid;
   logic        push_ready;
   rfa_cmd_type push_cmd;

   // Queue to back
   logic        cmd_valid;
   logic        cmd_pop;
   rfa_cmd_type cmd_data;

   // Decode and hold one command
   rfa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // Decouple intake from the walk sequencer
   rfa_cmd_fifo #(
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_cmd),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_pop),
      .pop_data   (cmd_data)
   );

   // Region table, walks and response register
   rfa_back #(
      .MAX_REGIONS (MAX_REGIONS),
      .PAGE_SHIFT  (PAGE_SHIFT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // An accepted request must be offered to the queue on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> push_valid)
      else $error("accepted request not held for the queue");

   // The back end pops only a non-empty queue
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

   // No response right after reset
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule
